// File: sv/airfoil_coefficient_polynomials_top_assert.svh
// Assertion macros shared by the airfoil coefficient block.
`ifndef AIRFOIL_COEFFICIENT_POLYNOMIALS_TOP_ASSERT_SVH
`define AIRFOIL_COEFFICIENT_POLYNOMIALS_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ACP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ACP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/acp_pkg.sv
`default_nettype none

package acp_pkg;

    localparam int AF        = 24;
    localparam int FRAC_BITS = 12;
    localparam int SHIFT     = AF - FRAC_BITS;
    localparam int IN_W      = 16;
    localparam int OUT_W     = 16;
    localparam int X_W       = 23;
    localparam int ACC_W     = 32;
    localparam int PROD_W    = ACC_W + X_W + 1;
    localparam int LIN_W     = 50;
    localparam int FIN_W     = ACC_W + 2;
    localparam int RND_BIT   = (SHIFT == 0) ? 0 : SHIFT - 1;

    // Thresholds and substitute angles with AF fraction bits.
    localparam logic [31:0] LIM_ZERO  = 32'd15099494;
    localparam logic [31:0] LIM_LIN   = 32'd1342177;
    localparam logic [31:0] LIM_HI    = 32'd5855248;
    localparam logic [31:0] SUBST_ANG = 32'd2919236;
    localparam logic [26:0] TWO_PI_A  = 27'd105414357;

    localparam logic signed [ACC_W-1:0] LIFT_POLY [4] = '{
        32'sd84907, 32'sd91803919, 32'sd268551219, -32'sd1093966758
    };
    localparam logic signed [ACC_W-1:0] MOM_POLY [5] = '{
        -32'sd22512, 32'sd6264210, -32'sd130812960, 32'sd809468795, -32'sd1428472568
    };
    localparam logic signed [ACC_W-1:0] DRAG_POLY [5] = '{
        32'sd184167, -32'sd6874666, 32'sd145272068, -32'sd891782850, 32'sd1856549945
    };

    typedef enum logic [1:0] {
        LIFT_ZERO = 2'd0,
        LIFT_LIN  = 2'd1,
        LIFT_FIT  = 2'd2
    } lift_sel_t;

    typedef struct packed {
        logic                     zero;
        logic                     neg;
        lift_sel_t                lift_sel;
        logic [X_W-1:0]           x_lm;
        logic [X_W-1:0]           x_dr;
        logic signed [ACC_W-1:0]  acc_lift;
        logic signed [ACC_W-1:0]  acc_mom;
        logic signed [ACC_W-1:0]  acc_drag;
    } stage_t;

    // One Horner step: round(acc * x / 2^AF), ties upwards, then add the coefficient.
    function automatic logic signed [ACC_W-1:0] horner_step(
        input logic signed [ACC_W-1:0] acc,
        input logic [X_W-1:0]          x,
        input logic signed [ACC_W-1:0] c
    );
        logic signed [PROD_W-1:0] prod;
        logic signed [PROD_W-1:0] sum;
        prod = acc * $signed({1'b0, x});
        sum  = prod + (PROD_W'(1) <<< (AF - 1));
        return ACC_W'(sum >>> AF) + c;
    endfunction

    // Linear lift region: round(2*pi*m) with AF fraction bits.
    function automatic logic signed [ACC_W-1:0] lift_linear(input logic [X_W-1:0] x);
        logic [LIN_W-1:0] prod;
        prod = LIN_W'(TWO_PI_A) * LIN_W'(x);
        prod = prod + (LIN_W'(1) << (AF - 1));
        return $signed(ACC_W'(prod >> AF));
    endfunction

    // Round to FRAC_BITS fraction bits, apply the sign and saturate.
    function automatic logic signed [OUT_W-1:0] finish(
        input logic signed [ACC_W-1:0] mag,
        input logic                    neg
    );
        logic signed [FIN_W-1:0] t;
        logic signed [FIN_W-1:0] r;
        t = FIN_W'(mag);
        if (SHIFT != 0) begin
            t = t + (FIN_W'(1) <<< RND_BIT);
        end
        r = t >>> SHIFT;
        if (neg) begin
            r = -r;
        end
        if (r > FIN_W'(32767)) begin
            return 16'sh7FFF;
        end else if (r < -FIN_W'(32768)) begin
            return 16'sh8000;
        end
        return OUT_W'(r);
    endfunction

endpackage

`default_nettype wire

// File: sv/airfoil_coefficient_polynomials_top.sv
// An angle goes through the input stage, four Horner stages and the output register.
// Throughput: one angle per clock cycle while m_ready is high; each Horner stage holds one
// multiply per polynomial, and a valid bit per stage means stalls only back up the pipe.
// Reset: aresetn is synchronous and active low; it clears all valid bits and sets
// coefficient_mode to zero (polynomial fits selected).
`default_nettype none

module airfoil_coefficient_polynomials_top (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic signed [acp_pkg::IN_W-1:0]  s_attack_angle,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic signed [acp_pkg::OUT_W-1:0]      m_lift_coeff,
    output logic signed [acp_pkg::OUT_W-1:0]      m_drag_coeff,
    output logic signed [acp_pkg::OUT_W-1:0]      m_moment_coeff,
    input  wire logic                             cfg_wr_en,
    input  wire logic                             cfg_wr_data
);
    import acp_pkg::*;

`include "airfoil_coefficient_polynomials_top_assert.svh"

    localparam int NS  = 5;
    localparam int OUT = NS + 1;

    logic                    mode_reg;
    logic [OUT:1]            valid_reg;
    logic [OUT:1]            valid_next;
    logic [OUT+1:1]          en;
    stage_t                  stage_reg  [1:NS];
    stage_t                  stage_next [1:NS];
    stage_t                  stage1_next;
    logic signed [OUT_W-1:0] lift_reg, drag_reg, mom_reg;
    logic signed [OUT_W-1:0] lift_next, drag_next, mom_next;
    logic [IN_W-1:0]         mag_in;
    logic [31:0]             m_in;

    // A stage may load when it is empty or when the stage after it moves on.
    always_comb begin
        en[OUT+1] = m_ready;
        for (int k = OUT; k >= 1; k--) begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign s_ready = en[1];

    always_comb begin
        valid_next[1] = en[1] ? s_valid : valid_reg[1];
        for (int k = 2; k <= OUT; k++) begin
            valid_next[k] = en[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    // Input stage: magnitude, range decisions and substituted angles.
    always_comb begin
        mag_in = s_attack_angle[IN_W-1] ? IN_W'(-s_attack_angle) : IN_W'(s_attack_angle);
        m_in   = 32'(mag_in) << SHIFT;

        stage1_next.zero = mode_reg;
        stage1_next.neg  = s_attack_angle[IN_W-1];
        stage1_next.x_lm = (m_in > LIM_HI) ? X_W'(SUBST_ANG) : m_in[X_W-1:0];
        stage1_next.x_dr = (m_in > LIM_HI) ? X_W'(LIM_HI) : m_in[X_W-1:0];
        if (m_in > LIM_ZERO) begin
            stage1_next.lift_sel = LIFT_ZERO;
        end else if (m_in <= LIM_LIN) begin
            stage1_next.lift_sel = LIFT_LIN;
        end else begin
            stage1_next.lift_sel = LIFT_FIT;
        end
        stage1_next.acc_lift = (stage1_next.lift_sel == LIFT_FIT) ? LIFT_POLY[3] : '0;
        stage1_next.acc_mom  = MOM_POLY[4];
        stage1_next.acc_drag = DRAG_POLY[4];
    end

    // Horner stages: stage k applies coefficient 5-k. Lift starts one stage later, and
    // its linear region is worked out in the first of these stages instead.
    always_comb begin
        stage_next[1] = stage1_next;
        for (int k = 2; k <= NS; k++) begin
            stage_next[k]          = stage_reg[k-1];
            stage_next[k].acc_mom  = horner_step(stage_reg[k-1].acc_mom,
                                                 stage_reg[k-1].x_lm, MOM_POLY[5-k]);
            stage_next[k].acc_drag = horner_step(stage_reg[k-1].acc_drag,
                                                 stage_reg[k-1].x_dr, DRAG_POLY[5-k]);
            if (k == 2) begin
                if (stage_reg[k-1].lift_sel == LIFT_LIN) begin
                    stage_next[k].acc_lift = lift_linear(stage_reg[k-1].x_lm);
                end
            end else if (stage_reg[k-1].lift_sel == LIFT_FIT) begin
                stage_next[k].acc_lift = horner_step(stage_reg[k-1].acc_lift,
                                                     stage_reg[k-1].x_lm, LIFT_POLY[5-k]);
            end
        end
    end

    always_comb begin
        if (stage_reg[NS].zero) begin
            lift_next = '0;
            drag_next = '0;
            mom_next  = '0;
        end else begin
            lift_next = finish(stage_reg[NS].acc_lift, stage_reg[NS].neg);
            drag_next = finish(stage_reg[NS].acc_drag, 1'b0);
            mom_next  = finish(stage_reg[NS].acc_mom, stage_reg[NS].neg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            mode_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (cfg_wr_en) begin
                mode_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 1; k <= NS; k++) begin
            if (en[k]) begin
                stage_reg[k] <= stage_next[k];
            end
        end
        if (en[OUT]) begin
            lift_reg <= lift_next;
            drag_reg <= drag_next;
            mom_reg  <= mom_next;
        end
    end

    assign m_valid        = valid_reg[OUT];
    assign m_lift_coeff   = lift_reg;
    assign m_drag_coeff   = drag_reg;
    assign m_moment_coeff = mom_reg;

    `ACP_ASSERT_NEXT(a_accept_fills_first, s_valid && s_ready, valid_reg[1],
        "Accepted word did not reach the first stage.")
    `ACP_ASSERT_NOW(a_stall_only_when_full, !s_ready, (&valid_reg) && !m_ready,
        "Input held off while the pipeline still had room.")
    `ACP_ASSERT_NOW(a_lift_zero_region,
        valid_reg[NS] && stage_reg[NS].lift_sel == LIFT_ZERO, stage_reg[NS].acc_lift == '0,
        "Lift accumulator not zero beyond the stall angle.")
    `ACP_ASSERT_NEXT(a_mode_forces_zero,
        valid_reg[NS] && en[OUT] && stage_reg[NS].zero,
        m_lift_coeff == '0 && m_drag_coeff == '0 && m_moment_coeff == '0,
        "Coefficients not forced to zero in zero mode.")

endmodule

`default_nettype wire

// File: tb/sv/tb_airfoil_coefficient_polynomials_top.sv
`default_nettype none

module tb_airfoil_coefficient_polynomials_top;

    import acp_pkg::*;

    localparam int  CLK_HALF  = 10;
    localparam int  FB        = 12;
    localparam int  AFB       = 24;

    // Thresholds and fit coefficients with AFB fraction bits.
    localparam longint ZERO_LIM  = 64'sd15099494;
    localparam longint LIN_LIM   = 64'sd1342177;
    localparam longint HI_LIM    = 64'sd5855248;
    localparam longint SUB_ANGLE = 64'sd2919236;
    localparam longint TWO_PI    = 64'sd105414357;

    localparam longint L0 = 64'sd84907;
    localparam longint L1 = 64'sd91803919;
    localparam longint L2 = 64'sd268551219;
    localparam longint L3 = -64'sd1093966758;
    localparam longint M0 = -64'sd22512;
    localparam longint M1 = 64'sd6264210;
    localparam longint M2 = -64'sd130812960;
    localparam longint M3 = 64'sd809468795;
    localparam longint M4 = -64'sd1428472568;
    localparam longint D0 = 64'sd184167;
    localparam longint D1 = -64'sd6874666;
    localparam longint D2 = 64'sd145272068;
    localparam longint D3 = -64'sd891782850;
    localparam longint D4 = 64'sd1856549945;

    typedef struct {
        logic signed [IN_W-1:0] angle;
        int                     gap;
    } angle_item_t;

    typedef struct {
        logic signed [OUT_W-1:0] lift;
        logic signed [OUT_W-1:0] drag;
        logic signed [OUT_W-1:0] moment;
    } coeff_word_t;

    logic                     aclk           = 1'b0;
    logic                     aresetn        = 1'b0;
    logic                     s_valid        = 1'b0;
    logic                     s_ready;
    logic signed [IN_W-1:0]   s_attack_angle = '0;
    logic                     m_valid;
    logic                     m_ready        = 1'b0;
    logic signed [OUT_W-1:0]  m_lift_coeff;
    logic signed [OUT_W-1:0]  m_drag_coeff;
    logic signed [OUT_W-1:0]  m_moment_coeff;
    logic                     cfg_wr_en      = 1'b0;
    logic                     cfg_wr_data    = 1'b0;

    angle_item_t pending_angles[$];
    coeff_word_t coeff_expected[$];
    bit          zero_mode  = 1'b0;
    bit          calm       = 1'b0;
    int          errors     = 0;

    angle_item_t drv_cur;
    bit          drv_have   = 1'b0;
    int          drv_wait   = 0;
    int          rdy_wait   = 0;

    airfoil_coefficient_polynomials_top i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_attack_angle (s_attack_angle),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_lift_coeff   (m_lift_coeff),
        .m_drag_coeff   (m_drag_coeff),
        .m_moment_coeff (m_moment_coeff),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data)
    );

    always #(CLK_HALF) aclk = ~aclk;

    // Rounds to nearest with ties towards plus infinity.
    function automatic longint round_down_by(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint horner_mac(longint acc, longint x, longint c);
        return round_down_by(acc * x, AFB) + c;
    endfunction

    function automatic logic signed [OUT_W-1:0] to_output(longint mag, bit neg);
        longint r;
        r = round_down_by(mag, AFB - FB);
        if (neg) begin
            r = -r;
        end
        if (r > 32767) begin
            r = 32767;
        end else if (r < -32768) begin
            r = -32768;
        end
        return OUT_W'(r);
    endfunction

    function automatic coeff_word_t predict_coeffs(logic signed [IN_W-1:0] angle);
        coeff_word_t w;
        longint      a;
        longint      m;
        longint      x;
        longint      lift;
        longint      drag;
        longint      mom;
        bit          neg;
        if (zero_mode) begin
            w.lift   = '0;
            w.drag   = '0;
            w.moment = '0;
            return w;
        end
        a   = longint'(angle) * (64'sd1 <<< (AFB - FB));
        neg = a < 0;
        m   = neg ? -a : a;
        // Lift and moment swap large angles for a fixed one; drag clamps instead.
        x = (m > HI_LIM) ? SUB_ANGLE : m;
        if (m > ZERO_LIM) begin
            lift = 0;
        end else if (m <= LIN_LIM) begin
            lift = round_down_by(TWO_PI * m, AFB);
        end else begin
            lift = horner_mac(horner_mac(horner_mac(L3, x, L2), x, L1), x, L0);
        end
        mom = horner_mac(horner_mac(horner_mac(horner_mac(M4, x, M3), x, M2), x, M1), x, M0);
        x = (m > HI_LIM) ? HI_LIM : m;
        drag = horner_mac(horner_mac(horner_mac(horner_mac(D4, x, D3), x, D2), x, D1), x, D0);
        w.lift   = to_output(lift, neg);
        w.drag   = to_output(drag, 1'b0);
        w.moment = to_output(mom, neg);
        return w;
    endfunction

    function automatic int draw_wait();
        if (calm || $urandom_range(0, 2) != 0) begin
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    function automatic void queue_angle(logic signed [IN_W-1:0] angle);
        angle_item_t it;
        it.angle = angle;
        it.gap   = draw_wait();
        pending_angles.insert(pending_angles.size(), it);
    endfunction

    function automatic logic signed [IN_W-1:0] random_angle();
        int       sel;
        int       mag;
        int       edges[5];
        sel = $urandom_range(0, 9);
        edges = '{327, 1429, 3686, 713, 0};
        if (sel <= 5) begin
            mag = $urandom_range(0, 4000);
        end else if (sel <= 7) begin
            return IN_W'($urandom_range(0, 65535));
        end else if (sel == 8) begin
            mag = edges[$urandom_range(0, 4)] + $urandom_range(0, 4) - 2;
            if (mag < 0) begin
                mag = 0;
            end
        end else begin
            case ($urandom_range(0, 2))
                0: return 16'sh7FFF;
                1: return 16'sh8000;
                default: return '0;
            endcase
        end
        return $urandom_range(0, 1) ? IN_W'(-mag) : IN_W'(mag);
    endfunction

    // Feeds angle words from the pending queue, honouring each word's lead-in gap.
    always @(posedge aclk) begin
        logic nxt_valid;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            drv_have = 1'b0;
        end else begin
            nxt_valid = s_valid;
            if (s_valid && s_ready) begin
                coeff_expected.insert(coeff_expected.size(), predict_coeffs(s_attack_angle));
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (!drv_have && pending_angles.size() > 0) begin
                    drv_cur  = pending_angles.pop_front();
                    drv_wait = drv_cur.gap;
                    drv_have = 1'b1;
                end
                if (drv_have) begin
                    if (drv_wait == 0) begin
                        s_attack_angle <= drv_cur.angle;
                        nxt_valid = 1'b1;
                        drv_have  = 1'b0;
                    end else begin
                        drv_wait--;
                    end
                end
            end
            s_valid <= nxt_valid;
        end
    end

    // Checks each result word against the oldest prediction and, at random, stalls between words.
    always @(posedge aclk) begin
        logic        nxt_ready;
        coeff_word_t exp_w;
        if (!aresetn) begin
            m_ready  <= 1'b0;
            rdy_wait = 0;
        end else begin
            nxt_ready = m_ready;
            if (m_valid && m_ready) begin
                if (coeff_expected.size() == 0) begin
                    $error("result word with no angle outstanding");
                    errors++;
                end else begin
                    exp_w = coeff_expected.pop_front();
                    if (m_lift_coeff !== exp_w.lift) begin
                        $error("lift_coeff: expected %0d, got %0d", exp_w.lift, m_lift_coeff);
                        errors++;
                    end
                    if (m_drag_coeff !== exp_w.drag) begin
                        $error("drag_coeff: expected %0d, got %0d", exp_w.drag, m_drag_coeff);
                        errors++;
                    end
                    if (m_moment_coeff !== exp_w.moment) begin
                        $error("moment_coeff: expected %0d, got %0d", exp_w.moment,
                               m_moment_coeff);
                        errors++;
                    end
                end
                rdy_wait  = draw_wait();
                nxt_ready = (rdy_wait == 0);
            end else if (!m_ready) begin
                if (rdy_wait > 0) begin
                    rdy_wait--;
                end
                if (rdy_wait == 0) begin
                    nxt_ready = 1'b1;
                end
            end
            m_ready <= nxt_ready;
        end
    end

    task automatic wait_drained();
        @(negedge aclk);
        while (pending_angles.size() > 0 || drv_have || s_valid || coeff_expected.size() > 0) begin
            @(negedge aclk);
        end
        repeat (8) @(negedge aclk);
    endtask

    task automatic set_coefficient_mode(bit mode);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        zero_mode = mode;
        @(negedge aclk);
    endtask

    initial begin
        logic signed [IN_W-1:0] corner[$];
        corner = {16'sd0, 16'sd1, -16'sd1, 16'sh7FFF, 16'sh8000, 16'sd327, 16'sd328,
                  -16'sd327, -16'sd328, 16'sd1429, 16'sd1430, -16'sd1430, 16'sd3686,
                  16'sd3687, -16'sd3686, -16'sd3687, 16'sd713, -16'sd713, 16'sd2048,
                  -16'sd4096};
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        set_coefficient_mode(1'b0);
        foreach (corner[i]) begin
            queue_angle(corner[i]);
        end
        wait_drained();

        repeat (600) queue_angle(random_angle());
        wait_drained();
        repeat (400) queue_angle(random_angle());
        wait_drained();

        // With the fits switched off every word must come back all zero.
        set_coefficient_mode(1'b1);
        queue_angle(16'sh7FFF);
        queue_angle(16'sh8000);
        queue_angle(16'sd500);
        repeat (200) queue_angle(random_angle());
        wait_drained();

        set_coefficient_mode(1'b0);
        calm = 1'b1;
        repeat (200) queue_angle(random_angle());
        wait_drained();

        if (coeff_expected.size() != 0) begin
            $error("%0d result words never arrived", coeff_expected.size());
            errors++;
        end
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #(4000000);
        $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// File: airfoil_coefficient_polynomials_top.f
+incdir+sv
sv/acp_pkg.sv
sv/airfoil_coefficient_polynomials_top.sv
tb/sv/tb_airfoil_coefficient_polynomials_top.sv
